// File: src/assert_macros.svh
// Assertion macros for the move-to-front history table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MFH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MFH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MFH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define MFH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/mfh_pkg.sv
// Shared types, codes and field layout of the move-to-front history table.
package mfh_pkg;

    localparam int DEPTH_DEF  = 32;
    localparam int KEY_W      = 32;
    localparam int SCROLL_W   = 20;
    localparam int ID_W       = 8;
    localparam int ACT_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int COLL_SHIFT = 24;

    // Layout of the input tdata word.
    localparam int IN_KEY_LSB   = 0;
    localparam int IN_PREV_LSB  = 32;
    localparam int IN_KEEP_BIT  = 64;
    localparam int IN_POS_LSB   = 65;
    localparam int IN_LEVEL_BIT = 85;
    localparam int IN_W         = 88;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD        = 3'd0,
        ACT_GET_PREV   = 3'd1,
        ACT_GET_SCROLL = 3'd2,
        ACT_LOG_SCROLL = 3'd3,
        ACT_CLEAR      = 3'd4,
        ACT_SAVE       = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        MARK_NONE   = 2'd0,
        MARK_NORMAL = 2'd1,
        MARK_SCROLL = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        SAVE_NONE  = 2'd0,
        SAVE_NOW   = 2'd1,
        SAVE_DEFER = 2'd2
    } save_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_MOVE = 1'b1
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [KEY_W-1:0]    prev;
        logic [SCROLL_W-1:0] scroll;
    } entry_t;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic look;        // compare the search key and latch the match
        logic shift;       // move entries one place back
        logic use_hit;     // shift up to the matching cell, else up to the count
        logic front_load;  // load the front cell from the controller
    } cell_ctrl_t;

endpackage

// File: src/mfh_cell.sv
// One table cell: stored entry, key compare, match latch and neighbor shift.
module mfh_cell
    import mfh_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    parameter int CELL_IDX    = 0,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] cmp_key,
    input  logic [CNT_W-1:0] count,
    input  entry_t           load_data,
    input  logic             hit_in,
    input  entry_t           sel_in,
    output entry_t           entry_out,
    output logic             hit_out,
    output entry_t           sel_out
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(CELL_IDX);

    entry_t entry_reg;
    logic   match_reg;
    logic   active;
    logic   load;

    assign active    = IDX_C < count;
    assign entry_out = entry_reg;
    assign hit_out   = hit_in | match_reg;
    assign sel_out   = entry_t'(sel_in | (match_reg ? entry_reg : '0));

    generate
        if (CELL_IDX == 0) begin : g_front
            assign load = ctrl.front_load;
        end else begin : g_body
            // Shift in from the neighbor in front: up to and including the
            // matching cell on a hit, up to the fill count on a miss.
            assign load = ctrl.shift & (ctrl.use_hit ? hit_out : (IDX_C <= count));
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctrl.look) begin
            match_reg <= active && (entry_reg.key == cmp_key);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= load_data;
        end
    end

endmodule

// File: src/mfh_ctrl.sv
// Controller: handshakes, action decode, fill count, change mark and result word.
module mfh_ctrl
    import mfh_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
    localparam int OUT_RAW_W  = VALUE_W + CNT_W + 2,
    localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic [ACT_W-1:0] s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [ID_W-1:0]  cfg_data,
    output cell_ctrl_t       cell_ctrl,
    output logic [KEY_W-1:0] cmp_key,
    output logic [CNT_W-1:0] count,
    output entry_t           front_data,
    input  entry_t           head_data,
    input  logic             hit,
    input  entry_t           sel_data
);

    state_t               state_reg, state_next;
    action_t              act_reg, act_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [KEY_W-1:0]     prev_reg, prev_next;
    logic                 keep_reg, keep_next;
    logic [SCROLL_W-1:0]  pos_reg, pos_next;
    logic                 level_reg, level_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    mark_t                mark_reg, mark_next;
    logic [ID_W-1:0]      id_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;
    logic                 out_found_reg, out_found_next;

    logic [KEY_W-1:0]     in_key;
    logic [KEY_W-1:0]     stamped_key;
    logic                 accept;
    logic                 found_n;
    logic [VALUE_W-1:0]   value_n;
    save_t                save_n;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_found_reg;
    assign count     = count_reg;

    // A key without a collection id takes the current one.
    assign in_key      = s_tdata[IN_KEY_LSB +: KEY_W];
    assign stamped_key = (in_key[KEY_W-1:COLL_SHIFT] == '0)
                       ? {id_reg, in_key[COLL_SHIFT-1:0]} : in_key;
    assign cmp_key     = (action_t'(s_tuser) == ACT_GET_SCROLL) ? in_key : stamped_key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mark_reg      <= MARK_NONE;
            id_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                id_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        key_reg       <= key_next;
        prev_reg      <= prev_next;
        keep_reg      <= keep_next;
        pos_reg       <= pos_next;
        level_reg     <= level_next;
        out_data_reg  <= out_data_next;
        out_found_reg <= out_found_next;
    end

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        prev_next      = prev_reg;
        keep_next      = keep_reg;
        pos_next       = pos_reg;
        level_next     = level_reg;
        count_next     = count_reg;
        mark_next      = mark_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_found_next = out_found_reg;
        s_tready       = 1'b0;
        accept         = 1'b0;
        cell_ctrl      = '0;
        front_data     = head_data;
        found_n        = 1'b0;
        value_n        = '0;
        save_n         = SAVE_NONE;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                accept         = s_tvalid;
                cell_ctrl.look = accept;
                if (accept) begin
                    state_next = ST_MOVE;
                    act_next   = action_t'(s_tuser);
                    key_next   = stamped_key;
                    prev_next  = s_tdata[IN_PREV_LSB +: KEY_W];
                    keep_next  = s_tdata[IN_KEEP_BIT];
                    pos_next   = s_tdata[IN_POS_LSB +: SCROLL_W];
                    level_next = s_tdata[IN_LEVEL_BIT];
                end
            end
            ST_MOVE: begin
                // Finish only when the result register is free or draining.
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                    unique case (act_reg)
                        ACT_ADD: begin
                            mark_next            = MARK_NORMAL;
                            cell_ctrl.shift      = 1'b1;
                            cell_ctrl.use_hit    = hit;
                            cell_ctrl.front_load = 1'b1;
                            found_n              = hit;
                            if (hit) begin
                                front_data.key    = sel_data.key;
                                front_data.prev   = (prev_reg != '0) ? prev_reg : sel_data.prev;
                                front_data.scroll = keep_reg ? sel_data.scroll : '0;
                            end else begin
                                front_data.key    = key_reg;
                                front_data.prev   = prev_reg;
                                front_data.scroll = '0;
                                if (count_reg != CNT_W'(TABLE_DEPTH)) begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        ACT_GET_PREV: begin
                            found_n = hit;
                            value_n = sel_data.prev;
                        end
                        ACT_GET_SCROLL: begin
                            found_n = hit;
                            value_n = VALUE_W'(sel_data.scroll);
                        end
                        ACT_LOG_SCROLL: begin
                            if (mark_reg != MARK_NORMAL) begin
                                mark_next = MARK_SCROLL;
                            end
                            cell_ctrl.front_load = 1'b1;
                            front_data.scroll    = pos_reg;
                        end
                        ACT_CLEAR: begin
                            count_next = '0;
                            mark_next  = MARK_NORMAL;
                        end
                        ACT_SAVE: begin
                            if (mark_reg != MARK_NONE) begin
                                if (level_reg || mark_reg == MARK_NORMAL) begin
                                    mark_next = MARK_NONE;
                                    save_n    = SAVE_NOW;
                                end else begin
                                    save_n = SAVE_DEFER;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_found_next = found_n;
                    out_data_next  = OUT_W'({save_n, count_next, value_n});
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/move_to_front_history_table_top.sv
// Top level of the move-to-front history table: cell chain and controller.
//
// A most-recent-first table of up to TABLE_DEPTH entries, each holding a
// 32-bit key, the key visited before it and a 20-bit scroll position. Every
// input word carries one action in s_tuser and gives exactly one result word.
// When a word is accepted every cell compares its key with the search key
// and latches the match; once the result register is free or draining, the
// match and the matching entry ripple through the cell chain to the front,
// the cells shift back by one place where needed, and the result is
// registered. The block takes no new word until it has finished the last.
// The result register holds its word until taken; while it is still full
// the block can accept one more word but will not finish it until the
// result register frees up. The collection id register is written through
// cfg_valid/cfg_data and must only be written while no word is in flight.
// Stored entries beyond the fill count are never looked at, so the table
// needs no clearing pass after reset.
`include "assert_macros.svh"

module move_to_front_history_table_top
    import mfh_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
    localparam int OUT_RAW_W  = VALUE_W + CNT_W + 2,
    localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Input word.
    input  logic             s_tvalid,
    output logic             s_tready,
    // s_tdata from bit 0: article_key[31:0], previous_key[63:32],
    // keep_position[64], scroll_position[84:65], save_level[85], zero pad.
    input  logic [IN_W-1:0]  s_tdata,
    // s_tuser: action[2:0].
    input  logic [ACT_W-1:0] s_tuser,
    // Result word.
    output logic             m_tvalid,
    input  logic             m_tready,
    // m_tdata from bit 0: result_value[31:0], entry_count[CNT_W-1+32:32],
    // save_result (next two bits), zero pad.
    output logic [OUT_W-1:0] m_tdata,
    // m_tuser: found.
    output logic             m_tuser,
    // Collection id register write.
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [ID_W-1:0]  cfg_data
);

    cell_ctrl_t       cell_ctrl;
    logic [KEY_W-1:0] cmp_key;
    logic [CNT_W-1:0] count;
    entry_t           front_data;
    entry_t           cell_data [TABLE_DEPTH];
    entry_t           sel_chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0] hit_chain;

    // The hit flag and the matching entry travel from the back of the chain
    // toward the front; the far end starts them empty.
    assign hit_chain[TABLE_DEPTH] = 1'b0;
    assign sel_chain[TABLE_DEPTH] = '0;

    mfh_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .cell_ctrl  (cell_ctrl),
        .cmp_key    (cmp_key),
        .count      (count),
        .front_data (front_data),
        .head_data  (cell_data[0]),
        .hit        (hit_chain[0]),
        .sel_data   (sel_chain[0])
    );

    // Cell zero is the most recent entry and loads from the controller;
    // every other cell loads from the cell in front of it.
    generate
        for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
            entry_t load_data;
            if (i == 0) begin : g_head
                assign load_data = front_data;
            end else begin : g_tail
                assign load_data = cell_data[i-1];
            end

            mfh_cell #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .CELL_IDX    (i)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (cell_ctrl),
                .cmp_key   (cmp_key),
                .count     (count),
                .load_data (load_data),
                .hit_in    (hit_chain[i+1]),
                .sel_in    (sel_chain[i+1]),
                .entry_out (cell_data[i]),
                .hit_out   (hit_chain[i]),
                .sel_out   (sel_chain[i])
            );
        end
    endgenerate

    // The fill count never exceeds the number of cells.
    `MFH_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count <= CNT_W'(TABLE_DEPTH), "fill count above table depth")

    // After an accepted word the block is busy finishing it.
    `MFH_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted while previous word unfinished")

    // A shift of the chain always comes with a new front entry and never
    // while words are being accepted.
    `MFH_ASSERT_IMPL(a_shift_with_front, aclk, aresetn, cell_ctrl.shift, cell_ctrl.front_load && !s_tready, "chain shift without front load")

endmodule
